[rtl/core/fbpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int DEF_NUM_BLOCKS = 64;

  localparam int REQ_W    = 20;
  localparam int OFF_W    = 24;
  localparam int BYTES_W  = 24;
  localparam int BSIZE_W  = 17;
  localparam int CFGIDX_W = 2;
  localparam int CFGDAT_W = 16;
  localparam int ALIGN_W  = 4;

  localparam logic [CFGIDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [CFGIDX_W-1:0] REG_ALIGN_LOG2 = 2'd1;

  localparam logic [CFGDAT_W-1:0] RST_BLOCK_SIZE = 16'd64;
  localparam logic [ALIGN_W-1:0]  RST_ALIGN_LOG2 = 4'd3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_PTR   = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_NULL      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_DIV,
    S_FREE,
    S_MULA,
    S_DONE
  } state_t;

endpackage

[rtl/core/fixed_block_pool_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Pool of equal blocks handed out and taken back through a LIFO free stack.
//
// Usage:
//   s_* carries one request per transfer: tuser = {free_is_null, op},
//   op 0 allocates, op 1 frees. m_* returns exactly one result per request.
//   cfg_* writes block size (index 0) and alignment log2 (index 1); write it
//   only while no request is in flight. cfg_ready is always high.
//   From accept to the result register, an allocate that pops a block
//   passes S_POP, S_MULA and S_DONE; a request rejected at accept (too
//   large, pool empty, null, offset out of range) passes S_MULA and S_DONE;
//   a free of an in-range offset runs the bit-serial divider that turns the
//   offset into a block index (S_DIV), then S_FREE, S_MULA and S_DONE. The
//   next request is taken from the cycle after the result register loads.
//   The free stack lives in a RAM with registered read; entries below the
//   lowest stack depth reached since reset read back as their own index, so
//   reset needs no sweep and the block takes requests right after reset.
//   Reset empties the result register and restores both registers.
//   A finished result waits in the output register while the receiver
//   stalls; the next request is accepted meanwhile and stalls before its own
//   result is loaded.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
  parameter int NUM_BLOCKS = fbpa_pkg::DEF_NUM_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [47:0]                   s_tdata,   // request_size, free_offset
  input  logic [1:0]                    s_tuser,   // op, free_is_null
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [47:0]                   m_tdata,   // block_offset, allocated_bytes
  output logic [2:0]                    m_tuser,   // status
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fbpa_pkg::CFGIDX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::CFGDAT_W-1:0] cfg_data
);

  localparam int IW    = $clog2(NUM_BLOCKS);
  localparam int CW    = $clog2(NUM_BLOCKS + 1);
  localparam int BW    = fbpa_pkg::BSIZE_W;
  localparam int PW    = CW + BW;
  localparam int CMPW  = (PW > fbpa_pkg::OFF_W) ? PW : fbpa_pkg::OFF_W;
  localparam int DVW   = BW + IW;
  localparam int RW    = (DVW > fbpa_pkg::OFF_W) ? DVW : fbpa_pkg::OFF_W;
  localparam int CNTW  = (IW > 1) ? $clog2(IW) : 1;

  // configuration
  logic [fbpa_pkg::CFGDAT_W-1:0] block_size;
  logic [fbpa_pkg::ALIGN_W-1:0]  align_log2;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= fbpa_pkg::RST_BLOCK_SIZE;
      align_log2 <= fbpa_pkg::RST_ALIGN_LOG2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbpa_pkg::REG_BLOCK_SIZE: block_size <= cfg_data;
        fbpa_pkg::REG_ALIGN_LOG2: align_log2 <= cfg_data[fbpa_pkg::ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // effective block size
  logic [BW-1:0] align;
  logic [BW-1:0] amask;
  logic [BW-1:0] bs_round;
  logic [BW-1:0] bs;
  logic [CMPW-1:0] limit;

  always_comb begin
    align    = BW'(1) << align_log2;
    amask    = align - BW'(1);
    bs_round = (BW'(block_size) + amask) & ~amask;
    bs       = (bs_round < align) ? align : bs_round;
    limit    = CMPW'(PW'(NUM_BLOCKS) * PW'(bs));
  end

  // request fields
  logic                         in_op;
  logic                         in_null;
  logic [fbpa_pkg::REQ_W-1:0]   in_req;
  logic [fbpa_pkg::OFF_W-1:0]   in_off;

  assign in_op   = s_tuser[0];
  assign in_null = s_tuser[1];
  assign in_req  = s_tdata[19:0];
  assign in_off  = s_tdata[43:20];

  // control state
  fbpa_pkg::state_t state, state_next;
  logic [CW-1:0]    free_cnt;
  logic [CW-1:0]    alloc_cnt;
  logic [CW-1:0]    low_mark;
  logic             out_valid;

  // payload
  fbpa_pkg::status_t          status;
  logic [fbpa_pkg::OFF_W-1:0] block_off;
  logic [fbpa_pkg::BYTES_W-1:0] bytes;
  logic                       use_ram;
  logic [RW-1:0]              rem;
  logic [DVW-1:0]             dv;
  logic [IW-1:0]              quot;
  logic [CNTW-1:0]            cnt;
  logic [fbpa_pkg::OFF_W-1:0] out_block;
  logic [fbpa_pkg::BYTES_W-1:0] out_bytes;
  fbpa_pkg::status_t          out_status;

  // strobes
  logic accept;
  logic load_out;
  logic ram_re;
  logic ram_we;
  logic do_pop;
  logic do_push;
  logic [IW-1:0] ram_raddr;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_rdata;

  // shared multiplier
  logic [CW-1:0]       mul_a;
  logic [PW-1:0]       prod;
  logic [PW+23:0]      prod_ext;
  logic [IW-1:0]       pop_idx;

  assign pop_idx  = use_ram ? ram_rdata : free_cnt[IW-1:0];
  assign mul_a    = (state == fbpa_pkg::S_POP) ? CW'(pop_idx) : alloc_cnt;
  assign prod     = PW'(mul_a) * PW'(bs);
  assign prod_ext = {{24{1'b0}}, prod};

  // divider step
  logic          div_ge;
  logic [RW-1:0] dv_ext;

  assign dv_ext = RW'(dv);
  assign div_ge = rem >= dv_ext;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fbpa_pkg::S_IDLE: begin
        if (accept) begin
          if (do_pop) begin
            state_next = fbpa_pkg::S_POP;
          end else if (in_op && !in_null && (CMPW'(in_off) < limit)) begin
            state_next = fbpa_pkg::S_DIV;
          end else begin
            state_next = fbpa_pkg::S_MULA;
          end
        end
      end
      fbpa_pkg::S_POP:  state_next = fbpa_pkg::S_MULA;
      fbpa_pkg::S_DIV:  state_next = (cnt == '0) ? fbpa_pkg::S_FREE : fbpa_pkg::S_DIV;
      fbpa_pkg::S_FREE: state_next = fbpa_pkg::S_MULA;
      fbpa_pkg::S_MULA: state_next = fbpa_pkg::S_DONE;
      fbpa_pkg::S_DONE: state_next = load_out ? fbpa_pkg::S_IDLE : fbpa_pkg::S_DONE;
      default:          state_next = fbpa_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = (state == fbpa_pkg::S_IDLE);
    accept    = s_tvalid && s_tready;
    do_pop    = accept && !in_op && (in_req <= fbpa_pkg::REQ_W'(bs)) && (free_cnt != '0);
    ram_re    = do_pop;
    ram_raddr = IW'(free_cnt - CW'(1));
    do_push   = (state == fbpa_pkg::S_FREE) && (rem == '0) &&
                (free_cnt < CW'(NUM_BLOCKS));
    ram_we    = do_push;
    ram_waddr = free_cnt[IW-1:0];
    load_out  = (state == fbpa_pkg::S_DONE) && (!out_valid || m_tready);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fbpa_pkg::S_IDLE;
      free_cnt  <= CW'(NUM_BLOCKS);
      alloc_cnt <= '0;
      low_mark  <= CW'(NUM_BLOCKS);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_pop) begin
        free_cnt  <= free_cnt - CW'(1);
        alloc_cnt <= alloc_cnt + CW'(1);
        if ((free_cnt - CW'(1)) < low_mark) begin
          low_mark <= free_cnt - CW'(1);
        end
      end else if (do_push) begin
        free_cnt <= free_cnt + CW'(1);
        if (alloc_cnt != '0) begin
          alloc_cnt <= alloc_cnt - CW'(1);
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      fbpa_pkg::S_IDLE: begin
        if (accept) begin
          block_off <= '0;
          use_ram   <= (free_cnt - CW'(1)) >= low_mark;
          rem       <= RW'(in_off);
          dv        <= DVW'(bs) << (IW - 1);
          quot      <= '0;
          cnt       <= CNTW'(IW - 1);
          if (!in_op) begin
            if (in_req > fbpa_pkg::REQ_W'(bs)) begin
              status <= fbpa_pkg::ST_TOO_LARGE;
            end else if (free_cnt == '0) begin
              status <= fbpa_pkg::ST_EMPTY;
            end else begin
              status <= fbpa_pkg::ST_OK;
            end
          end else if (in_null) begin
            status <= fbpa_pkg::ST_NULL;
          end else if (CMPW'(in_off) >= limit) begin
            status <= fbpa_pkg::ST_BAD_PTR;
          end else begin
            status <= fbpa_pkg::ST_OK;
          end
        end
      end
      fbpa_pkg::S_POP: begin
        block_off <= prod_ext[23:0];
      end
      fbpa_pkg::S_DIV: begin
        if (div_ge) begin
          rem <= rem - dv_ext;
        end
        quot <= IW'({quot, div_ge});
        dv   <= dv >> 1;
        cnt  <= cnt - CNTW'(1);
      end
      fbpa_pkg::S_FREE: begin
        if (rem != '0) begin
          status <= fbpa_pkg::ST_BAD_PTR;
        end else if (free_cnt >= CW'(NUM_BLOCKS)) begin
          status <= fbpa_pkg::ST_OVERFLOW;
        end
      end
      fbpa_pkg::S_MULA: begin
        bytes <= prod_ext[23:0];
      end
      default: ;
    endcase
    if (load_out) begin
      out_status <= status;
      out_block  <= block_off;
      out_bytes  <= bytes;
    end
  end

  fbpa_ram #(
    .WIDTH (IW),
    .DEPTH (NUM_BLOCKS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (quot),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_bytes, out_block};
  assign m_tuser  = out_status;

  a_free_cnt_range: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= CW'(NUM_BLOCKS))
    else $error("free count above pool size");

  a_alloc_cnt_range: assert property (@(posedge clk) disable iff (rst)
    alloc_cnt <= CW'(NUM_BLOCKS))
    else $error("allocated count above pool size");

  a_low_mark: assert property (@(posedge clk) disable iff (rst)
    low_mark <= free_cnt)
    else $error("fill mark above stack depth");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("stack push and pop in one cycle");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (state == fbpa_pkg::S_IDLE) && out_valid)
    else $error("result load did not return to idle");

endmodule

[rtl/core/fbpa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
